@@ rtl/csle_pkg.sv @@
// Shared types, symbol codes, marker tables and the base-7 digit split
// for the color symbol line encoder. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package csle_pkg;

  typedef enum logic [2:0] {
    SYM_BLACK   = 3'd0,
    SYM_RED     = 3'd1,
    SYM_GREEN   = 3'd2,
    SYM_YELLOW  = 3'd3,
    SYM_BLUE    = 3'd4,
    SYM_MAGENTA = 3'd5,
    SYM_CYAN    = 3'd6,
    SYM_WHITE   = 3'd7
  } color_t;

  localparam int START_LEN = 9;
  localparam int END_LEN   = 3;

  localparam color_t START_MARKER [START_LEN] = '{
    SYM_CYAN, SYM_RED, SYM_YELLOW, SYM_CYAN, SYM_YELLOW,
    SYM_MAGENTA, SYM_CYAN, SYM_RED, SYM_WHITE
  };
  localparam color_t END_MARKER [END_LEN] = '{SYM_CYAN, SYM_MAGENTA, SYM_WHITE};

  // Positions in the full 18-symbol sequence of one byte
  localparam int IDX_W = 5;
  localparam logic [IDX_W-1:0] IDX_START    = 5'd0;
  localparam logic [IDX_W-1:0] IDX_BYTE     = 5'd9;
  localparam logic [IDX_W-1:0] IDX_BYTE_END = 5'd11;
  localparam logic [IDX_W-1:0] IDX_CSUM     = 5'd12;
  localparam logic [IDX_W-1:0] IDX_END      = 5'd15;
  localparam logic [IDX_W-1:0] IDX_LAST     = 5'd17;

  typedef struct packed {
    logic [2:0] d2;  // v / 49
    logic [2:0] d1;  // (v / 7) % 7
    logic [2:0] d0;  // v % 7
  } digits_t;

  // Base-7 split of a byte by reciprocal multiplies; exact for 0..255.
  function automatic digits_t split7(input logic [7:0] v);
    logic [17:0] p49;
    logic [2:0]  q49;
    logic [5:0]  r49;
    logic [10:0] p7;
    logic [2:0]  q7;
    digits_t     d;
    p49  = 18'(v) * 18'd669;
    q49  = p49[17:15];
    r49  = 6'(v - 8'(q49) * 8'd49);
    p7   = 11'(r49) * 11'd37;
    q7   = p7[10:8];
    d.d2 = q49;
    d.d1 = q7;
    d.d0 = 3'(r49 - 6'(q7) * 6'd7);
    return d;
  endfunction

endpackage
`default_nettype wire

@@ rtl/csle_if.sv @@
// Valid/ready channel interfaces: byte input and color symbol output.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
interface csle_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       frame_end;
  modport source (output valid, output data_byte, output frame_end, input ready);
  modport sink   (input valid, input data_byte, input frame_end, output ready);
endinterface

interface csle_sym_if;
  logic       valid;
  logic       ready;
  logic [2:0] symbol;
  logic       symbol_final;
  modport source (output valid, output symbol, output symbol_final, input ready);
  modport sink   (input valid, input symbol, input symbol_final, output ready);
endinterface
`default_nettype wire

@@ rtl/color_symbol_line_encoder.sv @@
// Color symbol line encoder, top level.
// Depends on csle_pkg and the channel interfaces in csle_if.sv.
//
// Usage:
//  - in_bus (sink): one beat per frame byte, data_byte plus frame_end on the
//    last byte. A byte that opens a frame first yields the nine-symbol start
//    marker; every byte yields its three base-7 digits, MSB first; the last
//    byte also yields the checksum byte (negated byte sum mod 256) and the
//    three-symbol end marker. A symbol equal to the one before it goes out
//    as white, except the first symbol of a frame.
//  - out_bus (source): one color symbol per beat, symbol_final high on the
//    last symbol that an input byte causes.
//  - Flow: a byte is first held in the item registers, and its symbols then
//    pass through the output register. One symbol leaves per cycle while
//    out_bus does not stall.
//  - The next byte is accepted in the cycle its predecessor's last symbol
//    moves to the output register, so symbols stream with no gap.
//  - A stall on out_bus freezes the output register and the sequencer;
//    in_bus.ready drops until the held byte's last symbol gets out.
//  - Reset (rst_n low, synchronous): no frame open, sum and previous
//    symbol cleared, both channels empty.
`timescale 1ns / 1ps
`default_nettype none
module color_symbol_line_encoder
  import csle_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  csle_byte_if.sink  in_bus,
  csle_sym_if.source out_bus
);

  // Frame state
  logic [7:0] running_sum_r, running_sum_nxt;
  logic       inside_r, inside_nxt;
  logic [2:0] prev_r;

  // Held byte and its position in the symbol sequence
  logic             item_valid_r;
  logic [7:0]       item_byte_r;
  logic [7:0]       item_csum_r;
  logic             item_last_r;
  logic [IDX_W-1:0] idx_r, idx_nxt;

  // Output register
  logic       out_valid_r;
  logic [2:0] out_sym_r, out_sym_nxt;
  logic       out_final_r;

  logic       in_accept, emit, at_end;
  logic [7:0] sum_base, sum_new;
  digits_t    byte_dig, csum_dig;
  logic [2:0] raw_sym;

  assign emit   = item_valid_r && (!out_valid_r || out_bus.ready);
  assign at_end = (idx_r == (item_last_r ? IDX_LAST : IDX_BYTE_END));

  assign in_bus.ready = !item_valid_r || (emit && at_end);
  assign in_accept    = in_bus.valid && in_bus.ready;

  // Sum for the incoming byte; a new frame starts from zero
  assign sum_base = inside_r ? running_sum_r : 8'd0;
  assign sum_new  = sum_base + in_bus.data_byte;

  always_comb begin
    running_sum_nxt = running_sum_r;
    inside_nxt      = inside_r;
    idx_nxt         = idx_r;
    if (emit) begin
      idx_nxt = idx_r + 1'b1;
    end
    if (in_accept) begin
      idx_nxt         = inside_r ? IDX_BYTE : IDX_START;
      running_sum_nxt = in_bus.frame_end ? 8'd0 : sum_new;
      inside_nxt      = !in_bus.frame_end;
    end
  end

  assign byte_dig = split7(item_byte_r);
  assign csum_dig = split7(item_csum_r);

  always_comb begin
    case (idx_r) inside
      [IDX_START:IDX_BYTE-1'b1]:  raw_sym = START_MARKER[idx_r[3:0]];
      IDX_BYTE:                   raw_sym = byte_dig.d2;
      IDX_BYTE + 5'd1:            raw_sym = byte_dig.d1;
      IDX_BYTE_END:               raw_sym = byte_dig.d0;
      IDX_CSUM:                   raw_sym = csum_dig.d2;
      IDX_CSUM + 5'd1:            raw_sym = csum_dig.d1;
      IDX_CSUM + 5'd2:            raw_sym = csum_dig.d0;
      [IDX_END:IDX_LAST]:         raw_sym = END_MARKER[2'(idx_r - IDX_END)];
      default:                    raw_sym = SYM_WHITE;
    endcase
    // Repeat suppression; the frame's first symbol is never compared
    if (idx_r != IDX_START && raw_sym == prev_r) begin
      out_sym_nxt = SYM_WHITE;
    end else begin
      out_sym_nxt = raw_sym;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_sum_r <= 8'd0;
      inside_r      <= 1'b0;
      prev_r        <= SYM_BLACK;
      item_valid_r  <= 1'b0;
      out_valid_r   <= 1'b0;
      idx_r         <= IDX_START;
    end else begin
      running_sum_r <= running_sum_nxt;
      inside_r      <= inside_nxt;
      idx_r         <= idx_nxt;
      if (in_accept) begin
        item_valid_r <= 1'b1;
      end else if (emit && at_end) begin
        item_valid_r <= 1'b0;
      end
      if (emit) begin
        out_valid_r <= 1'b1;
        prev_r      <= out_sym_nxt;
      end else if (out_bus.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_accept) begin
      item_byte_r <= in_bus.data_byte;
      item_csum_r <= 8'd0 - sum_new;
      item_last_r <= in_bus.frame_end;
    end
    if (emit) begin
      out_sym_r   <= out_sym_nxt;
      out_final_r <= at_end;
    end
  end

  assign out_bus.valid        = out_valid_r;
  assign out_bus.symbol       = out_sym_r;
  assign out_bus.symbol_final = out_final_r;

endmodule
`default_nettype wire

@@ sim/tb_color_symbol_line_encoder.sv @@
// Self-checking testbench for color_symbol_line_encoder: directed byte table,
// then random frames, checked beat by beat against a behavioral encoder.
// Depends on csle_pkg, csle_if.sv and the RTL top level.
`timescale 1ns / 1ps
module tb_color_symbol_line_encoder;
  import csle_pkg::*;

  localparam int N_RANDOM_TOTAL = 310;  // directed rows included
  localparam int LONG_STALL     = 80;   // cycles of receiver hold-off
  localparam int STALL_AT_BEAT  = 700;
  localparam int DRAIN_AT_ITEM  = 160;

  // One row of the directed table. Where typed_known is set, typed holds the
  // 18 expected symbols in octal, first symbol in the top digit.
  typedef struct packed {
    logic [7:0]  data;
    logic        last;
    logic        typed_known;
    logic [53:0] typed;
  } stim_row_t;

  typedef struct packed {
    color_t sym;
    logic   fin;
  } symbol_beat_t;

  localparam int N_DIRECTED = 20;
  localparam stim_row_t DIRECTED_ROWS [N_DIRECTED] = '{
    // one-byte frame of 0 right after reset: start, 000, checksum 0, end
    '{8'd0,   1'b1, 1'b1, 54'o613635617070707657},
    // one-byte frame of 255: checksum is 1
    '{8'd255, 1'b1, 1'b1, 54'o613635617513071657},
    '{8'd57,  1'b0, 1'b0, 54'o0},  // 1 1 1: repeated digits go white
    '{8'd114, 1'b0, 1'b0, 54'o0},  // 2 2 2
    '{8'd171, 1'b0, 1'b0, 54'o0},  // 3 3 3
    '{8'd228, 1'b0, 1'b0, 54'o0},  // 4 4 4
    '{8'd255, 1'b0, 1'b0, 54'o0},
    '{8'd0,   1'b0, 1'b0, 54'o0},
    '{8'd48,  1'b0, 1'b0, 54'o0},  // 0 6 6
    '{8'd6,   1'b1, 1'b0, 54'o0},
    '{8'd128, 1'b0, 1'b0, 54'o0},
    '{8'd128, 1'b1, 1'b0, 54'o0},  // sum wraps to 0, checksum 0
    '{8'd1,   1'b0, 1'b0, 54'o0},
    '{8'd254, 1'b0, 1'b0, 54'o0},
    '{8'd7,   1'b1, 1'b0, 54'o0},
    '{8'd170, 1'b0, 1'b0, 54'o0},
    '{8'd85,  1'b1, 1'b0, 54'o0},
    '{8'd249, 1'b1, 1'b0, 54'o0},  // 5 0 4, one-byte frame again
    '{8'd49,  1'b0, 1'b0, 54'o0},
    '{8'd98,  1'b1, 1'b0, 54'o0}
  };

  logic clk;
  logic rst_n;

  csle_byte_if in_chan ();
  csle_sym_if  out_chan ();

  color_symbol_line_encoder uut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_chan),
    .out_bus (out_chan)
  );

  // Behavioral encoder state
  logic [7:0]   frame_sum;
  logic         frame_open;
  color_t       last_color;

  symbol_beat_t byte_symbols[$];     // symbols of the byte just accepted
  symbol_beat_t pending_symbols[$];  // symbols still owed by the block

  int unsigned  mismatches;
  int unsigned  out_beats;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // A symbol equal to the one before goes out white, unless it opens a frame.
  function automatic void emit_color(input color_t c, input logic opens_frame);
    color_t       s;
    symbol_beat_t beat;
    s = c;
    if (!opens_frame && s == last_color) begin
      s = SYM_WHITE;
    end
    beat.sym     = s;
    beat.fin     = 1'b0;
    byte_symbols = {byte_symbols, beat};
    last_color   = s;
  endfunction

  // Base-7 digits, most significant first
  function automatic void emit_digits(input logic [7:0] b);
    emit_color(color_t'(3'(b / 8'd49)), 1'b0);
    emit_color(color_t'(3'((b / 8'd7) % 8'd7)), 1'b0);
    emit_color(color_t'(3'(b % 8'd7)), 1'b0);
  endfunction

  function automatic void encode_byte(input logic [7:0] b, input logic last);
    byte_symbols.delete();
    if (!frame_open) begin
      emit_color(START_MARKER[0], 1'b1);
      for (int i = 1; i < START_LEN; i++) begin
        emit_color(START_MARKER[i], 1'b0);
      end
      frame_open = 1'b1;
      frame_sum  = 8'd0;
    end
    emit_digits(b);
    frame_sum = frame_sum + b;
    if (last) begin
      emit_digits(8'd0 - frame_sum);
      for (int i = 0; i < END_LEN; i++) begin
        emit_color(END_MARKER[i], 1'b0);
      end
      frame_sum  = 8'd0;
      frame_open = 1'b0;
    end
    byte_symbols[byte_symbols.size() - 1].fin = 1'b1;
  endfunction

  // Idle gap before a beat; zero while in a burst stretch.
  function automatic int unsigned draw_gap(input logic burst);
    return burst ? 0 : $urandom_range(0, 10);
  endfunction

  // Offer one byte at the falling edge, hold it until accepted, then book
  // its symbols. Valid stays high into the next call, which either replaces
  // the payload (no gap) or drops valid for the gap.
  task automatic offer_byte(input logic [7:0] b, input logic last, input logic burst,
                            input logic typed_known, input logic [53:0] typed);
    int unsigned  gap;
    symbol_beat_t want;
    gap = draw_gap(burst);
    @(negedge clk);
    if (gap != 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_chan.valid     <= 1'b1;
    in_chan.data_byte <= b;
    in_chan.frame_end <= last;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    encode_byte(b, last);
    if (typed_known) begin
      // hand-derived expectation replaces the behavioral one
      for (int i = 0; i < 18; i++) begin
        want.sym        = color_t'(typed[53 - 3 * i -: 3]);
        want.fin        = (i == 17);
        pending_symbols = {pending_symbols, want};
      end
    end else begin
      pending_symbols = {pending_symbols, byte_symbols};
    end
  endtask

  // Receiver: random hold-off per beat, burst stretches without any, and one
  // long stall so the block backs up into its input.
  initial begin
    int unsigned  gap;
    logic         burst;
    symbol_beat_t want;
    out_chan.ready = 1'b0;
    out_beats      = 0;
    @(posedge rst_n);
    forever begin
      burst = ((out_beats / 150) % 3) == 2;
      gap   = (out_beats == STALL_AT_BEAT) ? LONG_STALL : draw_gap(burst);
      @(negedge clk);
      if (gap != 0) begin
        out_chan.ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_chan.ready <= 1'b1;
      @(posedge clk);
      while (!out_chan.valid) @(posedge clk);
      out_beats++;
      if (pending_symbols.size() == 0) begin
        $error("symbol: expected none, got %0d", out_chan.symbol);
        mismatches++;
      end else begin
        want = pending_symbols.pop_front();
        if (out_chan.symbol !== want.sym) begin
          $error("symbol: expected %0d, got %0d", want.sym, out_chan.symbol);
          mismatches++;
        end
        if (out_chan.symbol_final !== want.fin) begin
          $error("symbol_final: expected %0d, got %0d", want.fin, out_chan.symbol_final);
          mismatches++;
        end
      end
    end
  end

  // Stimulus and end of run
  initial begin
    int unsigned items_sent;
    int unsigned frame_len;
    logic        last;
    rst_n              = 1'b0;
    in_chan.valid      = 1'b0;
    in_chan.data_byte  = 8'd0;
    in_chan.frame_end  = 1'b0;
    mismatches         = 0;
    frame_sum          = 8'd0;
    frame_open         = 1'b0;
    last_color         = SYM_BLACK;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (DIRECTED_ROWS[i]) begin
      offer_byte(DIRECTED_ROWS[i].data, DIRECTED_ROWS[i].last, 1'b0,
                 DIRECTED_ROWS[i].typed_known, DIRECTED_ROWS[i].typed);
    end
    items_sent = N_DIRECTED;

    // Random frames: mostly several bytes, some single-byte frames.
    while (items_sent < N_RANDOM_TOTAL) begin
      frame_len = ($urandom_range(0, 4) == 0) ? 1 : $urandom_range(2, 16);
      for (int k = 0; k < frame_len; k++) begin
        if (items_sent == DRAIN_AT_ITEM) begin
          // sender goes quiet until the block has nothing left to say
          @(negedge clk);
          in_chan.valid <= 1'b0;
          while (pending_symbols.size() != 0) @(negedge clk);
        end
        last = (k == frame_len - 1);
        offer_byte(8'($urandom_range(0, 255)), last, ((items_sent / 40) % 3) == 1,
                   1'b0, 54'o0);
        items_sent++;
      end
    end
    @(negedge clk);
    in_chan.valid <= 1'b0;

    while (pending_symbols.size() != 0) @(posedge clk);
    // catch any stray beat after the last expected one
    repeat (40) @(posedge clk);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run
  initial begin
    #5_000_000;
    $display("status: fail");
    $finish;
  end

endmodule
